>>> hdl/tgdh_pkg.sv
package tgdh_pkg;

	localparam int RAW_W = 12;
	localparam int CELL_W = 4;
	localparam int CNT_W_DEFAULT = 8;
	localparam int DIV_W = 17;

	localparam logic [11:0] X_OFFSET_RST = 12'd2185;
	localparam logic [11:0] X_SPAN_RST = 12'(3977 - 2185);
	localparam logic [3:0] X_CELLS_RST = 4'd14;
	localparam logic [11:0] Y_OFFSET_RST = 12'd2185;
	localparam logic [11:0] Y_SPAN_RST = 12'(3849 - 2185);
	localparam logic [3:0] Y_CELLS_RST = 4'd13;
	localparam logic [7:0] THRESH_RST = 8'd5;
	localparam logic [1:0] SLACK_RST = 2'd1;
	localparam logic [11:0] PRESS_MAX = 12'h0FFF;

	typedef enum logic [2:0] {
		REG_X_OFFSET = 3'd0,
		REG_X_SPAN = 3'd1,
		REG_X_CELLS = 3'd2,
		REG_Y_OFFSET = 3'd3,
		REG_Y_SPAN = 3'd4,
		REG_Y_CELLS = 3'd5,
		REG_THRESH = 3'd6,
		REG_SLACK = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] x_offset;
		logic [11:0] x_span;
		logic [3:0] x_cells;
		logic [11:0] y_offset;
		logic [11:0] y_span;
		logic [3:0] y_cells;
		logic [7:0] thresh;
		logic [1:0] slack;
	} cfg_t;

	typedef struct packed {
		logic x_zero;
		logic y_zero;
		logic z_zero;
		logic [DIV_W-1:0] x_num;
		logic [DIV_W-1:0] x_den;
		logic [DIV_W-1:0] y_num;
		logic [DIV_W-1:0] y_den;
		logic [11:0] z1;
		logic [11:0] z2;
		logic [3:0] x_cells;
		logic [3:0] y_cells;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} back_st_t;

	typedef enum logic [1:0] {
		OP_X,
		OP_Y,
		OP_Z
	} op_t;

	function automatic logic in_rect(input logic [3:0] x, input logic [3:0] y,
			input logic [3:0] xl, input logic [3:0] yl,
			input logic [3:0] xh, input logic [3:0] yh);
		in_rect = (x >= xl) && (x <= xh) && (y >= yl) && (y <= yh);
	endfunction

endpackage

>>> hdl/tgdh_front.sv
module tgdh_front
	import tgdh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [63:0] in_data,
	input cfg_t cfg,
	output logic q_valid,
	input logic q_ready,
	output job_t q_job
);

	logic [11:0] rx, ry;
	logic [11:0] xs, ys;
	logic [11:0] dx, dy;
	job_t job;
	job_t slot_q [2];
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	logic push, pop;

	assign rx = in_data[15:4];
	assign ry = in_data[31:20];
	assign xs = (cfg.x_span == 12'd0) ? 12'd1 : cfg.x_span;
	assign ys = (cfg.y_span == 12'd0) ? 12'd1 : cfg.y_span;
	assign dx = rx - cfg.x_offset;
	assign dy = ry - cfg.y_offset;

	always_comb begin
		job.x_zero = (rx <= cfg.x_offset) || (cfg.x_cells == 4'd0);
		job.y_zero = (ry <= cfg.y_offset) || (cfg.y_cells == 4'd0);
		job.x_num = DIV_W'({dx, 1'b0} * cfg.x_cells) + DIV_W'(xs);
		job.x_den = DIV_W'({xs, 1'b0});
		job.y_num = DIV_W'({dy, 1'b0} * cfg.y_cells) + DIV_W'(ys);
		job.y_den = DIV_W'({ys, 1'b0});
		job.z1 = in_data[43:32];
		job.z2 = in_data[59:48];
		job.z_zero = (in_data[59:48] == 12'd0);
		job.x_cells = cfg.x_cells;
		job.y_cells = cfg.y_cells;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> hdl/tgdh_div.sv
module tgdh_div
	import tgdh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIV_W-1:0] num,
	input logic [DIV_W-1:0] den,
	output logic busy,
	output logic [DIV_W-1:0] quot
);

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q, quo_q, den_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W:0] trial;

	assign busy = (step_q != '0);
	assign quot = quo_q;
	assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(DIV_W);
		end else if (busy) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

endmodule

>>> hdl/tgdh_back.sv
module tgdh_back
	import tgdh_pkg::*;
#(
	parameter int COUNT_BITS = CNT_W_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input job_t q_job,
	input cfg_t cfg,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] out_data
);

	localparam int CMP_W = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;

	back_st_t st_q, st_d;
	op_t op_q, op_d;
	job_t job_q;
	logic take;
	logic div_start, div_busy;
	logic [DIV_W-1:0] div_num, div_den, div_quot;
	logic [3:0] cx_q, cy_q, cx_sat, cy_sat;
	logic [11:0] pr_n;
	logic [3:0] prev_x_q, prev_y_q;
	logic [COUNT_BITS-1:0] stab_q, stab_n;
	logic [1:0] slack_q, slack_n;
	logic [2:0] slack_inc;
	logic tog_q, tog_n;
	logic [2:0] die;
	logic start_h;
	logic ov_q;
	logic [31:0] od_q;
	logic finish;
	logic [CMP_W-1:0] thr_ext;

	tgdh_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quot(div_quot)
	);

	assign q_ready = (st_q == ST_IDLE);
	assign take = q_valid && q_ready;

	always_comb begin
		st_d = st_q;
		op_d = op_q;
		div_start = 1'b0;
		div_num = job_q.x_num;
		div_den = job_q.x_den;
		finish = 1'b0;
		unique case (op_q)
			OP_X: begin
				div_num = job_q.x_num;
				div_den = job_q.x_den;
			end
			OP_Y: begin
				div_num = job_q.y_num;
				div_den = job_q.y_den;
			end
			default: begin
				div_num = DIV_W'(job_q.z1);
				div_den = DIV_W'(job_q.z2);
			end
		endcase
		unique case (st_q)
			ST_IDLE: begin
				if (take) begin
					st_d = ST_DIV;
					op_d = OP_X;
				end
			end
			ST_DIV: begin
				div_start = 1'b1;
				st_d = ST_DONE;
			end
			ST_DONE: begin
				if (!div_busy) begin
					if (op_q == OP_Z) begin
						if (!ov_q || out_ready) begin
							finish = 1'b1;
							st_d = ST_IDLE;
						end
					end else begin
						op_d = (op_q == OP_X) ? OP_Y : OP_Z;
						st_d = ST_DIV;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign cx_sat = job_q.x_zero ? 4'd0 :
		((div_quot > DIV_W'(job_q.x_cells)) ? job_q.x_cells : div_quot[3:0]);
	assign cy_sat = job_q.y_zero ? 4'd0 :
		((div_quot > DIV_W'(job_q.y_cells)) ? job_q.y_cells : div_quot[3:0]);
	assign pr_n = job_q.z_zero ? PRESS_MAX : div_quot[11:0];

	assign thr_ext = CMP_W'(cfg.thresh);
	assign slack_inc = {1'b0, slack_q} + 3'd1;

	always_comb begin
		stab_n = stab_q;
		slack_n = slack_q;
		if (cx_q != prev_x_q || cy_q != prev_y_q) begin
			if (CMP_W'(stab_q) < thr_ext) begin
				stab_n = '0;
			end else if (slack_inc > {1'b0, cfg.slack}) begin
				stab_n = '0;
				slack_n = 2'd0;
			end else begin
				slack_n = slack_inc[1:0];
			end
		end else begin
			if (stab_q != '1) stab_n = stab_q + 1'b1;
			slack_n = 2'd0;
		end
		tog_n = (CMP_W'(stab_n) >= thr_ext) ? ~tog_q : 1'b0;
		die = 3'd0;
		if (in_rect(cx_q, cy_q, 4'd1, 4'd8, 4'd4, 4'd12)) die = 3'd1;
		else if (in_rect(cx_q, cy_q, 4'd10, 4'd8, 4'd13, 4'd12)) die = 3'd2;
		else if (in_rect(cx_q, cy_q, 4'd6, 4'd4, 4'd9, 4'd8)) die = 3'd3;
		else if (in_rect(cx_q, cy_q, 4'd1, 4'd1, 4'd4, 4'd5)) die = 3'd4;
		else if (in_rect(cx_q, cy_q, 4'd10, 4'd1, 4'd13, 4'd5)) die = 3'd5;
		start_h = in_rect(cx_q, cy_q, 4'd3, 4'd3, 4'd11, 4'd5);
		if (!tog_n) begin
			die = 3'd0;
			start_h = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			op_q <= OP_X;
			prev_x_q <= 4'd0;
			prev_y_q <= 4'd0;
			stab_q <= '0;
			slack_q <= 2'd0;
			tog_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			op_q <= op_d;
			if (finish) begin
				prev_x_q <= cx_q;
				prev_y_q <= cy_q;
				stab_q <= stab_n;
				slack_q <= slack_n;
				tog_q <= tog_n;
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) job_q <= q_job;
		if (st_q == ST_DONE && !div_busy) begin
			if (op_q == OP_X) cx_q <= cx_sat;
			if (op_q == OP_Y) cy_q <= cy_sat;
		end
		if (finish) begin
			od_q <= {7'd0, start_h, die, tog_n, pr_n, cy_q, cx_q};
		end
	end

	assign out_valid = ov_q;
	assign out_data = od_q;

endmodule

>>> hdl/touch_grid_debounce_hit_test_core.sv
// Touch grid debounce and hit test.
// s_axis: one transfer carries X, Y, Z1, Z2 raw controller words.
// m_axis: one transfer per input: X cell, Y cell, pressure ratio, touch
// pulse, die hit and start hit.
// cfg: index/data write port for offsets, spans, cell counts, threshold,
// slack limit; write only while idle.
// A two-entry queue sits between the front classifier and the back end.
// The back end runs three divisions (X cell, Y cell, Z1/Z2) on one shared
// 17-bit restoring divider, one quotient bit a cycle, and takes the next item
// from the queue only after the result for the last one is registered.
// The result register holds until taken; while the receiver stalls, the
// back end waits with the next item ready and the queue still takes up to
// two more items.
// Reset clears the debounce state, the queue and the registers to defaults.
module touch_grid_debounce_hit_test_core
	import tgdh_pkg::*;
#(
	parameter int COUNT_BITS = CNT_W_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata, // x_word, y_word, z1_word, z2_word
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // x_cell, y_cell, pressure_ratio,
	                                  // touch_pulse, die_hit, start_hit
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [11:0] cfg_data
);

	cfg_t cfg_q;
	logic q_valid, q_ready;
	job_t q_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{X_OFFSET_RST, X_SPAN_RST, X_CELLS_RST, Y_OFFSET_RST,
				Y_SPAN_RST, Y_CELLS_RST, THRESH_RST, SLACK_RST};
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_X_OFFSET: cfg_q.x_offset <= cfg_data;
				REG_X_SPAN: cfg_q.x_span <= cfg_data;
				REG_X_CELLS: cfg_q.x_cells <= cfg_data[3:0];
				REG_Y_OFFSET: cfg_q.y_offset <= cfg_data;
				REG_Y_SPAN: cfg_q.y_span <= cfg_data;
				REG_Y_CELLS: cfg_q.y_cells <= cfg_data[3:0];
				REG_THRESH: cfg_q.thresh <= cfg_data[7:0];
				REG_SLACK: cfg_q.slack <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	tgdh_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .in_data(s_axis_tdata), .cfg(cfg_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
	);

	tgdh_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_job(q_job), .cfg(cfg_q), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);

endmodule

>>> test/touch_grid_debounce_hit_test_core_test.sv
module touch_grid_debounce_hit_test_core_test;
	import tgdh_pkg::*;

	typedef struct packed {
		logic [15:0] z2_word;
		logic [15:0] z1_word;
		logic [15:0] y_word;
		logic [15:0] x_word;
	} sample_t;

	typedef struct packed {
		logic [6:0] pad;
		logic start_hit;
		logic [2:0] die_hit;
		logic touch_pulse;
		logic [11:0] pressure_ratio;
		logic [3:0] y_cell;
		logic [3:0] x_cell;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;

	touch_grid_debounce_hit_test_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	cfg_t cur_cfg;
	logic [3:0] last_x, last_y;
	logic [7:0] hold_count;
	logic [1:0] move_count;
	logic pulse;

	sample_t pending_samples[$];
	hit_t expected_hits[$];
	int errors = 0;
	int hits_seen = 0;
	int pulses_seen = 0;
	longint cycles = 0;
	bit sender_hold = 1'b0;
	bit in_fire = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;

	function automatic logic [3:0] grid_cell(logic [11:0] raw, logic [11:0] offset,
			logic [11:0] span, logic [3:0] cells);
		logic [31:0] d, q, sp;
		sp = (span == 0) ? 32'd1 : 32'(span);
		if (raw <= offset)
			return 4'd0;
		d = 32'(raw) - 32'(offset);
		q = (2 * d * cells + sp) / (2 * sp);
		if (q > cells)
			q = cells;
		return q[3:0];
	endfunction

	function automatic logic box(logic [3:0] x, logic [3:0] y, int xl, int yl, int xh, int yh);
		return x >= xl && x <= xh && y >= yl && y <= yh;
	endfunction

	task automatic predict_hit(sample_t s);
		hit_t h;
		logic [11:0] z1, z2;
		h = '0;
		h.x_cell = grid_cell(s.x_word[15:4], cur_cfg.x_offset, cur_cfg.x_span, cur_cfg.x_cells);
		h.y_cell = grid_cell(s.y_word[15:4], cur_cfg.y_offset, cur_cfg.y_span, cur_cfg.y_cells);
		z1 = s.z1_word[11:0];
		z2 = s.z2_word[11:0];
		h.pressure_ratio = (z2 == 0) ? 12'hFFF : z1 / z2;
		if (h.x_cell != last_x || h.y_cell != last_y) begin
			if (hold_count < cur_cfg.thresh) begin
				hold_count = 0;
			end else if (3'(move_count) + 3'd1 > 3'(cur_cfg.slack)) begin
				hold_count = 0;
				move_count = 0;
			end else begin
				move_count = move_count + 2'd1;
			end
		end else begin
			if (hold_count != 8'hFF)
				hold_count = hold_count + 8'd1;
			move_count = 0;
		end
		last_x = h.x_cell;
		last_y = h.y_cell;
		pulse = (hold_count >= cur_cfg.thresh) ? ~pulse : 1'b0;
		h.touch_pulse = pulse;
		if (pulse) begin
			if (box(h.x_cell, h.y_cell, 1, 8, 4, 12)) h.die_hit = 3'd1;
			else if (box(h.x_cell, h.y_cell, 10, 8, 13, 12)) h.die_hit = 3'd2;
			else if (box(h.x_cell, h.y_cell, 6, 4, 9, 8)) h.die_hit = 3'd3;
			else if (box(h.x_cell, h.y_cell, 1, 1, 4, 5)) h.die_hit = 3'd4;
			else if (box(h.x_cell, h.y_cell, 10, 1, 13, 5)) h.die_hit = 3'd5;
			h.start_hit = box(h.x_cell, h.y_cell, 3, 3, 11, 5);
		end
		expected_hits.push_back(h);
	endtask

	always @(negedge clk) begin
		if (!s_axis_tvalid || in_fire) begin
			if (pending_samples.size() == 0 || sender_hold || !arst_n) begin
				s_axis_tvalid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_samples.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
				end
			end
		end
		stall_phase = (stall_phase + 1) % 97;
		if (stall_phase < 30)
			m_axis_tready <= 1'b1;
		else if (stall_phase < 60)
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		else
			m_axis_tready <= ($urandom_range(0, 1) == 0) ? 1'b1 : ($urandom_range(0, 9) == 0);
	end

	always @(posedge clk) begin
		hit_t got, want;
		cycles <= cycles + 1;
		in_fire = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_fire)
			predict_hit(sample_t'(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = hit_t'(m_axis_tdata);
			hits_seen++;
			if (got.touch_pulse)
				pulses_seen++;
			if (expected_hits.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer %h", $time, m_axis_tdata);
			end else begin
				want = expected_hits.pop_front();
				if (got.x_cell !== want.x_cell || got.y_cell !== want.y_cell
						|| got.pressure_ratio !== want.pressure_ratio
						|| got.touch_pulse !== want.touch_pulse
						|| got.die_hit !== want.die_hit || got.start_hit !== want.start_hit) begin
					errors++;
					$display("%0t: expected x%0d y%0d p%0d t%0d d%0d s%0d, got x%0d y%0d p%0d t%0d d%0d s%0d",
						$time, want.x_cell, want.y_cell, want.pressure_ratio, want.touch_pulse,
						want.die_hit, want.start_hit, got.x_cell, got.y_cell, got.pressure_ratio,
						got.touch_pulse, got.die_hit, got.start_hit);
				end
			end
		end
		if (cycles > 2000000) begin
			$display("touch_grid_debounce_hit_test_core: mismatch");
			$finish;
		end
	end

	task automatic drain;
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [11:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_X_OFFSET: cur_cfg.x_offset = value;
			REG_X_SPAN: cur_cfg.x_span = value;
			REG_X_CELLS: cur_cfg.x_cells = value[3:0];
			REG_Y_OFFSET: cur_cfg.y_offset = value;
			REG_Y_SPAN: cur_cfg.y_span = value;
			REG_Y_CELLS: cur_cfg.y_cells = value[3:0];
			REG_THRESH: cur_cfg.thresh = value[7:0];
			REG_SLACK: cur_cfg.slack = value[1:0];
			default: ;
		endcase
	endtask

	function automatic sample_t any_sample();
		return sample_t'({$urandom, $urandom});
	endfunction

	function automatic logic [15:0] near_word(logic [11:0] offset, logic [11:0] span);
		int raw;
		raw = int'(offset) + $urandom_range(0, int'(span) + 200) - 60;
		if (raw < 0) raw = 0;
		if (raw > 4095) raw = 4095;
		return {12'(raw), 4'($urandom)};
	endfunction

	task automatic queue_touches(int n);
		sample_t s;
		int held;
		held = 0;
		for (int i = 0; i < n; i++) begin
			if (held == 0) begin
				s = any_sample();
				s.x_word = near_word(cur_cfg.x_offset, cur_cfg.x_span);
				s.y_word = near_word(cur_cfg.y_offset, cur_cfg.y_span);
				held = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 14);
			end else begin
				s.z1_word = 16'($urandom);
				s.z2_word = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
				s.x_word[3:0] = 4'($urandom);
				if ($urandom_range(0, 7) == 0)
					s = any_sample();
			end
			held--;
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		sample_t s;
		cur_cfg = '{X_OFFSET_RST, X_SPAN_RST, X_CELLS_RST, Y_OFFSET_RST, Y_SPAN_RST,
			Y_CELLS_RST, THRESH_RST, SLACK_RST};
		last_x = 0; last_y = 0; hold_count = 0; move_count = 0; pulse = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		pending_samples.push_back('0);
		pending_samples.push_back('1);
		pending_samples.push_back({16'h0000, 16'h0FFF, 16'hFFFF, 16'h0000});
		pending_samples.push_back({16'h0001, 16'h0FFF, 16'h88F0, 16'h88A0});
		pending_samples.push_back({16'h0FFF, 16'h0001, 16'hAAAA, 16'h5555});
		// hold cells in three of the die areas long enough to qualify
		for (int k = 0; k < 3; k++)
			for (int r = 0; r < 7; r++) begin
				s.x_word = {12'(2185 + 128 * (k == 0 ? 2 : k == 1 ? 12 : 7)), 4'h0};
				s.y_word = {12'(2185 + 128 * (k == 0 ? 10 : k == 1 ? 3 : 6)), 4'h0};
				s.z1_word = 16'h0800; s.z2_word = 16'h0003;
				pending_samples.push_back(s);
			end
		drain();

		queue_touches(150);
		while (pending_samples.size() > 75)
			@(posedge clk);
		sender_hold = 1'b1;
		while (s_axis_tvalid || expected_hits.size() != 0)
			@(posedge clk);
		sender_hold = 1'b0;
		drain();

		write_reg(REG_X_OFFSET, 12'd0);
		write_reg(REG_X_SPAN, 12'd4095);
		write_reg(REG_X_CELLS, 12'd15);
		write_reg(REG_Y_OFFSET, 12'd0);
		write_reg(REG_Y_SPAN, 12'd1);
		write_reg(REG_Y_CELLS, 12'd1);
		write_reg(REG_THRESH, 12'd1);
		write_reg(REG_SLACK, 12'd3);
		queue_touches(120);
		drain();

		write_reg(REG_X_OFFSET, 12'd4095);
		write_reg(REG_X_SPAN, 12'd0);
		write_reg(REG_X_CELLS, 12'd0);
		write_reg(REG_Y_OFFSET, 12'd1000);
		write_reg(REG_Y_SPAN, 12'd300);
		write_reg(REG_Y_CELLS, 12'd15);
		write_reg(REG_THRESH, 12'd0);
		write_reg(REG_SLACK, 12'd0);
		queue_touches(80);
		drain();

		write_reg(REG_X_OFFSET, 12'd500);
		write_reg(REG_X_SPAN, 12'd900);
		write_reg(REG_X_CELLS, 12'd14);
		write_reg(REG_Y_OFFSET, 12'd700);
		write_reg(REG_Y_SPAN, 12'd1200);
		write_reg(REG_Y_CELLS, 12'd13);
		write_reg(REG_THRESH, 12'd255);
		write_reg(REG_SLACK, 12'd2);
		for (int i = 0; i < 270; i++) begin
			s = any_sample();
			s.x_word = {12'd950, 4'($urandom)};
			s.y_word = {12'd1300, 4'($urandom)};
			if (i > 262) s = any_sample();
			pending_samples.push_back(s);
		end
		drain();

		write_reg(REG_THRESH, 12'd3);
		queue_touches(100);
		drain();

		$display("covered %0d results, %0d with the touch pulse set, over five settings",
			hits_seen, pulses_seen);
		if (errors == 0)
			$display("touch_grid_debounce_hit_test_core: match");
		else
			$display("touch_grid_debounce_hit_test_core: mismatch");
		$finish;
	end

endmodule

>>> files.f
hdl/tgdh_pkg.sv
hdl/tgdh_front.sv
hdl/tgdh_div.sv
hdl/tgdh_back.sv
hdl/touch_grid_debounce_hit_test_core.sv
test/touch_grid_debounce_hit_test_core_test.sv
